// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/abt_pkg.sv =====
// ----------------------------------------------------------------------------
// abt_pkg
// Shared widths, codes and reset values of the adaptive box threshold.
// ----------------------------------------------------------------------------
package abt_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 8;
	localparam int SIZE_W  = 9;
	localparam int HALF_W  = 8;
	localparam int PCT_W   = 7;
	localparam int CFG_W   = 9;
	localparam int IDX_W   = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH       = 2'd0,
		REG_IMAGE_HEIGHT      = 2'd1,
		REG_HALF_WINDOW       = 2'd2,
		REG_THRESHOLD_PERCENT = 2'd3
	} reg_idx_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST       = 9'd256;
	localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST      = 9'd256;
	localparam logic [HALF_W-1:0] HALF_WINDOW_RST       = 8'd16;
	localparam logic [PCT_W-1:0]  THRESHOLD_PERCENT_RST = 7'd15;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

endpackage

// ===== design/abt_if.sv =====
// ----------------------------------------------------------------------------
// abt_if
// Request channels of the adaptive box threshold: load/query in, result out.
// ----------------------------------------------------------------------------
interface abt_in_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [abt_pkg::PIX_W-1:0]  pixel;
	logic                       first;
	logic [abt_pkg::COORD_W-1:0] col;
	logic [abt_pkg::COORD_W-1:0] row;

	modport source (output valid, output op, output pixel, output first,
		output col, output row, input ready);
	modport sink (input valid, input op, input pixel, input first,
		input col, input row, output ready);
endinterface

interface abt_out_if;
	logic valid;
	logic ready;
	logic white;

	modport source (output valid, output white, input ready);
	modport sink (input valid, input white, output ready);
endinterface

// ===== design/abt_ram.sv =====
// ----------------------------------------------------------------------------
// abt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module abt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/adaptive_box_threshold.sv =====
// ----------------------------------------------------------------------------
// adaptive_box_threshold
// Loads a grey image into a pixel RAM and an integral-image RAM, then answers
// box-mean threshold queries from four integral corners and the pixel itself.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                        | per request
//  item     | in  | op, pixel, first, col, row     | load or query
//  result   | out | white                          | one per query
//  cfg      | in  | cfg_we, cfg_index, cfg_data    | register write
//
//  Load: one per cycle while idle; the integral entry above is read from RAM
//  and the new entry is written in the next cycle, with forwarding of the
//  entry just written. Query: box, four corner reads of the single integral
//  read port, then sum, multiply and compare; items wait until it is done.
//  Reset: asynchronous, clears position, row sum, registers and control;
//  the RAMs are not cleared. A waiting result does not block loads.
// ----------------------------------------------------------------------------
module adaptive_box_threshold #(
	parameter int MAX_WIDTH  = abt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = abt_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [abt_pkg::IDX_W-1:0]  cfg_index,
	input  logic [abt_pkg::CFG_W-1:0]  cfg_data,
	abt_in_if.sink                     item,
	abt_out_if.source                  result
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RHW    = $clog2(MAX_HEIGHT);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int RSW    = CW + abt_pkg::PIX_W;
	localparam int IW     = AW + abt_pkg::PIX_W;
	localparam int SW     = IW + 2;
	localparam int XW     = (CW > abt_pkg::COORD_W ? CW : abt_pkg::COORD_W) + 1;
	localparam int YW     = (RHW > abt_pkg::COORD_W ? RHW : abt_pkg::COORD_W) + 1;
	localparam int CNT_W  = CW + RHW;
	localparam int CP_W   = CNT_W + abt_pkg::PIX_W;
	localparam int LHS_W  = CP_W + abt_pkg::PCT_W;
	localparam int RHS_W  = SW - 1 + abt_pkg::PCT_W;
	localparam int CMP_W  = LHS_W > RHS_W ? LHS_W : RHS_W;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_BOX  = 9'b000000010,
		S_RD0  = 9'b000000100,
		S_RD1  = 9'b000001000,
		S_RD2  = 9'b000010000,
		S_RD3  = 9'b000100000,
		S_SUM  = 9'b001000000,
		S_MUL  = 9'b010000000,
		S_CMP  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [abt_pkg::SIZE_W-1:0] width_q;
	logic [abt_pkg::SIZE_W-1:0] height_q;
	logic [abt_pkg::HALF_W-1:0] half_q;
	logic [abt_pkg::PCT_W-1:0]  pct_q;

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [abt_pkg::PCT_W-1:0] factor;

	logic [CW-1:0]  col_q;
	logic [RHW-1:0] row_q;
	logic [RSW-1:0] rs_q;

	logic [CW-1:0]  c0, c1, col_nx;
	logic [CW:0]    c3;
	logic [RHW-1:0] r0, r2, row_nx;
	logic [RHW:0]   r1, r3;
	logic [RSW-1:0] rs_new;
	logic [AW-1:0]  addr_s0, above_s0;

	logic                       valid_s1;
	logic [AW-1:0]              addr_s1;
	logic [RSW-1:0]             rs_s1;
	logic                       has_above_s1;
	logic [abt_pkg::PIX_W-1:0]  pix_s1;
	logic                       fwd_s1;
	logic [IW-1:0]              fwd_data_s1;
	logic [IW-1:0]              above_val;
	logic [IW-1:0]              acc;

	logic load_acc, query_acc;

	logic [CW-1:0]  qx, x_q, x1_q, x2_q, x1_n, x2_n, qc;
	logic [RHW-1:0] qy, y_q, y1_q, y2_q, y1_n, y2_n, qr;
	logic [XW-1:0]  x_hi, w_last;
	logic [YW-1:0]  y_hi, h_last;
	logic [AW-1:0]  qaddr;

	logic [abt_pkg::PIX_W-1:0] pix_q;
	logic [CNT_W-1:0]          count_q;
	logic [CP_W-1:0]           cp_q;
	logic [LHS_W-1:0]          lhs_q;
	logic [SW-1:0]             sum_q;
	logic [RHS_W-1:0]          rhs_q;
	logic                      ovalid_q;
	logic                      white_q;
	logic                      out_load;

	logic [IW-1:0]             irdata;
	logic [abt_pkg::PIX_W-1:0] prdata;
	logic [AW-1:0]             iraddr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= abt_pkg::IMAGE_WIDTH_RST;
			height_q <= abt_pkg::IMAGE_HEIGHT_RST;
			half_q   <= abt_pkg::HALF_WINDOW_RST;
			pct_q    <= abt_pkg::THRESHOLD_PERCENT_RST;
		end else if (cfg_we) begin
			unique case (abt_pkg::reg_idx_t'(cfg_index))
				abt_pkg::REG_IMAGE_WIDTH:       width_q  <= cfg_data;
				abt_pkg::REG_IMAGE_HEIGHT:      height_q <= cfg_data;
				abt_pkg::REG_HALF_WINDOW:       half_q   <= cfg_data[abt_pkg::HALF_W-1:0];
				abt_pkg::REG_THRESHOLD_PERCENT: pct_q    <= cfg_data[abt_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_q);
		end
		factor = abt_pkg::PCT_MAX - ((pct_q > abt_pkg::PCT_MAX) ? abt_pkg::PCT_MAX : pct_q);
	end

	assign item.ready = (state_q == S_IDLE);
	assign load_acc   = item.valid && item.ready && (item.op == abt_pkg::OP_LOAD);
	assign query_acc  = item.valid && item.ready && (item.op == abt_pkg::OP_QUERY);

	// load position, row sum and addresses
	always_comb begin
		c0 = item.first ? '0 : col_q;
		r0 = item.first ? '0 : row_q;
		if ((CW+1)'(c0) >= (CW+1)'(eff_w)) begin
			c1 = '0;
			r1 = {1'b0, r0} + (RHW+1)'(1);
		end else begin
			c1 = c0;
			r1 = {1'b0, r0};
		end
		r2 = (r1 >= (RHW+1)'(eff_h)) ? '0 : r1[RHW-1:0];
		c3 = {1'b0, c1} + (CW+1)'(1);
		if (c3 >= (CW+1)'(eff_w)) begin
			col_nx = '0;
			r3     = {1'b0, r2} + (RHW+1)'(1);
			row_nx = (r3 >= (RHW+1)'(eff_h)) ? '0 : r3[RHW-1:0];
		end else begin
			col_nx = c3[CW-1:0];
			r3     = {1'b0, r2};
			row_nx = r2;
		end
		rs_new   = ((c1 == '0) ? '0 : rs_q) + RSW'(item.pixel);
		addr_s0  = AW'(r2) * AW'(MAX_WIDTH) + AW'(c1);
		above_s0 = addr_s0 - AW'(MAX_WIDTH);
	end

	assign above_val = fwd_s1 ? fwd_data_s1 : irdata;
	assign acc = IW'(rs_s1) + (has_above_s1 ? above_val : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			rs_q     <= '0;
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= load_acc;
			fwd_s1   <= load_acc && valid_s1 && (above_s0 == addr_s1);
			if (load_acc) begin
				col_q <= col_nx;
				row_q <= row_nx;
				rs_q  <= rs_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_acc) begin
			addr_s1      <= addr_s0;
			rs_s1        <= rs_new;
			has_above_s1 <= (r2 != '0);
			pix_s1       <= item.pixel;
		end
		fwd_data_s1 <= acc;
	end

	// query clamp and box corners
	always_comb begin
		qx = (XW'(item.col) < XW'(eff_w)) ? CW'(item.col) : CW'(eff_w - WW'(1));
		qy = (YW'(item.row) < YW'(eff_h)) ? RHW'(item.row) : RHW'(eff_h - HW'(1));
		w_last = XW'(eff_w) - XW'(1);
		h_last = YW'(eff_h) - YW'(1);
		x_hi   = XW'(x_q) + XW'(half_q);
		y_hi   = YW'(y_q) + YW'(half_q);
		x2_n   = (x_hi > w_last) ? CW'(w_last) : CW'(x_hi);
		y2_n   = (y_hi > h_last) ? RHW'(h_last) : RHW'(y_hi);
		x1_n   = (XW'(x_q) > XW'(half_q)) ? CW'(XW'(x_q) - XW'(half_q)) : '0;
		y1_n   = (YW'(y_q) > YW'(half_q)) ? RHW'(YW'(y_q) - YW'(half_q)) : '0;
	end

	always_comb begin
		case (state_q)
			S_RD0:   begin qr = y2_q; qc = x2_q; end
			S_RD1:   begin qr = y1_q; qc = x1_q; end
			S_RD2:   begin qr = y1_q; qc = x2_q; end
			S_RD3:   begin qr = y2_q; qc = x1_q; end
			default: begin qr = y_q;  qc = x_q;  end
		endcase
		qaddr  = AW'(qr) * AW'(MAX_WIDTH) + AW'(qc);
		iraddr = (state_q == S_IDLE) ? above_s0 : qaddr;
	end

	assign out_load = (state_q == S_CMP) && (!ovalid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (query_acc) state_q <= S_BOX;
				S_BOX:   state_q <= S_RD0;
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_RD3;
				S_RD3:   state_q <= S_SUM;
				S_SUM:   state_q <= S_MUL;
				S_MUL:   state_q <= S_CMP;
				S_CMP:   if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			x_q <= qx;
			y_q <= qy;
		end
		case (state_q)
			S_BOX: begin
				x1_q <= x1_n;
				x2_q <= x2_n;
				y1_q <= y1_n;
				y2_q <= y2_n;
			end
			S_RD0: begin
				pix_q   <= prdata;
				count_q <= CNT_W'(x2_q - x1_q) * CNT_W'(y2_q - y1_q);
			end
			S_RD1: begin
				sum_q <= SW'(irdata);
				cp_q  <= CP_W'(count_q) * CP_W'(pix_q);
			end
			S_RD2: begin
				sum_q <= sum_q + SW'(irdata);
				lhs_q <= LHS_W'(cp_q) * LHS_W'(abt_pkg::PCT_MAX);
			end
			S_RD3:   sum_q <= sum_q - SW'(irdata);
			S_SUM:   sum_q <= sum_q - SW'(irdata);
			S_MUL:   rhs_q <= RHS_W'(sum_q[SW-2:0]) * RHS_W'(factor);
			default: ;
		endcase
		if (out_load) begin
			if (sum_q[SW-1]) begin
				white_q <= (factor == '0);
			end else begin
				white_q <= !(CMP_W'(lhs_q) < CMP_W'(rhs_q));
			end
		end
	end

	assign result.valid = ovalid_q;
	assign result.white = white_q;

	abt_ram #(
		.WIDTH (IW),
		.DEPTH (DEPTH)
	) u_integral_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (acc),
		.raddr (iraddr),
		.rdata (irdata)
	);

	abt_ram #(
		.WIDTH (abt_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_pixel_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.raddr (qaddr),
		.rdata (prdata)
	);

endmodule

// ===== design/abt_checker.sv =====
// ----------------------------------------------------------------------------
// abt_checker
// Port-level checks of the adaptive box threshold, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abt_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic item_op,
	input logic result_valid,
	input logic result_ready,
	input logic result_white
);

	logic load_acc;
	logic query_acc;

	assign load_acc  = item_valid && item_ready && (item_op == abt_pkg::OP_LOAD);
	assign query_acc = item_valid && item_ready && (item_op == abt_pkg::OP_QUERY);

	// a query holds the block for its corner reads and arithmetic
	`ASSERT_NXT(a_query_busy, clk, arst_n, query_acc, !item_ready ##1 !item_ready ##1 !item_ready ##1 !item_ready ##1 !item_ready ##1 !item_ready ##1 !item_ready)

	// loads never produce a result
	`ASSERT_NXT(a_load_silent, clk, arst_n, load_acc && !result_valid, !result_valid)

	// a new result only follows a busy cycle
	`ASSERT_IMP(a_result_after_busy, clk, arst_n, $rose(result_valid), !$past(item_ready))

	// hold a stalled result
	`ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_white))

endmodule

bind adaptive_box_threshold abt_checker u_abt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_op      (item.op),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_white (result.white)
);
